>>> rtl/core/lwmbe_pkg.sv
// Shared types and constants for the LCD window / mono bitmap expander.
package lwmbe_pkg;

  localparam int EXT_W        = 13;
  localparam int MAX_EXTENT   = 4096;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int PIX_PER_BYTE = 8;
  localparam int STEP_W       = 4;

  localparam logic ACT_WINDOW = 1'b0;
  localparam logic ACT_BITMAP = 1'b1;

  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_PIXFMT   = 8'h3A;
  localparam logic [7:0] PIXFMT_565   = 8'h55;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  // window write sequence positions
  localparam logic [STEP_W-1:0] WS_COL_CMD = 4'd0;
  localparam logic [STEP_W-1:0] WS_XS_HI   = 4'd1;
  localparam logic [STEP_W-1:0] WS_XS_LO   = 4'd2;
  localparam logic [STEP_W-1:0] WS_XE_HI   = 4'd3;
  localparam logic [STEP_W-1:0] WS_XE_LO   = 4'd4;
  localparam logic [STEP_W-1:0] WS_ROW_CMD = 4'd5;
  localparam logic [STEP_W-1:0] WS_YS_HI   = 4'd6;
  localparam logic [STEP_W-1:0] WS_YS_LO   = 4'd7;
  localparam logic [STEP_W-1:0] WS_YE_HI   = 4'd8;
  localparam logic [STEP_W-1:0] WS_YE_LO   = 4'd9;
  localparam logic [STEP_W-1:0] WS_FMT_CMD = 4'd10;
  localparam logic [STEP_W-1:0] WS_FMT_DAT = 4'd11;
  localparam logic [STEP_W-1:0] WS_MEM_CMD = 4'd12;

  typedef enum logic {
    JOB_WINDOW = 1'b0,
    JOB_PIXELS = 1'b1
  } job_kind_t;

  typedef struct packed {
    logic              action;
    logic [11:0]       x_start;
    logic [11:0]       y_start;
    logic [EXT_W-1:0]  win_width;
    logic [EXT_W-1:0]  win_height;
    logic [15:0]       fore_color;
    logic [15:0]       back_color;
    logic [7:0]        bitmap_byte;
  } in_word_t;

  typedef struct packed {
    logic        is_data;
    logic [15:0] bus_value;
    logic        last;
  } out_word_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [11:0]       x_start;
    logic [11:0]       y_start;
    logic [15:0]       x_end;
    logic [15:0]       y_end;
    logic [7:0]        bits;
    logic [STEP_W-1:0] count;
    logic [15:0]       fore;
    logic [15:0]       back;
  } job_t;

endpackage

>>> rtl/core/lcd_window_mono_bitmap_expander.sv
// Top level of the LCD window / mono bitmap expander.
//
//   channel | ports                      | word
//   input   | in_push, in_full, in_word   | window open or one bitmap byte
//   result  | out_pop, out_empty, out_word| one LCD bus write
//
// One bus write leaves per cycle from the sequencer unless the output stalls; a window
// gives 13 writes, a bitmap byte 0 to 8 (one per pixel left in the row, none past the window).
// Input words are accepted while the 4-deep job queue has room.
// Reset (rst_n low, synchronous) clears window state, queue and output stage.
// A stalled output holds the sequencer; the front keeps filling the queue.
module lcd_window_mono_bitmap_expander (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  lwmbe_pkg::in_word_t  in_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output lwmbe_pkg::out_word_t out_word
);

  logic            q_push, q_full, q_pop, q_empty;
  lwmbe_pkg::job_t q_in_job, q_head_job;

  assign in_full = q_full;

  lwmbe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_in_job)
  );

  lwmbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_head_job)
  );

  lwmbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

>>> rtl/core/lwmbe_front.sv
// Front end: accepts input words, tracks window state, issues jobs.
module lwmbe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  lwmbe_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              q_push,
  output lwmbe_pkg::job_t   q_job
);

  logic [lwmbe_pkg::EXT_W-1:0] width_r, width_nxt;
  logic [lwmbe_pkg::EXT_W-1:0] height_r, height_nxt;
  logic [lwmbe_pkg::EXT_W-1:0] col_r, col_nxt;
  logic [lwmbe_pkg::EXT_W-1:0] row_r, row_nxt;
  logic [15:0]                 fore_r, fore_nxt;
  logic [15:0]                 back_r, back_nxt;

  logic                        accept;
  logic [lwmbe_pkg::EXT_W-1:0] w_clamp, h_clamp;
  logic [lwmbe_pkg::EXT_W-1:0] remain, col_step;
  logic                        pix_ok;

  assign accept = in_push && !q_full;

  assign w_clamp = (16'(in_word.win_width) > 16'(lwmbe_pkg::MAX_EXTENT)) ?
                   lwmbe_pkg::EXT_W'(lwmbe_pkg::MAX_EXTENT) : in_word.win_width;
  assign h_clamp = (16'(in_word.win_height) > 16'(lwmbe_pkg::MAX_EXTENT)) ?
                   lwmbe_pkg::EXT_W'(lwmbe_pkg::MAX_EXTENT) : in_word.win_height;

  assign pix_ok   = (width_r != '0) && (height_r != '0) && (row_r < height_r);
  assign remain   = width_r - col_r;
  assign col_step = col_r + lwmbe_pkg::EXT_W'(lwmbe_pkg::PIX_PER_BYTE);

  always_comb begin
    q_job         = '0;
    q_job.x_start = in_word.x_start;
    q_job.y_start = in_word.y_start;
    q_job.x_end   = 16'(16'(in_word.x_start) + 16'(w_clamp) - 16'd1);
    q_job.y_end   = 16'(16'(in_word.y_start) + 16'(h_clamp) - 16'd1);
    q_job.bits    = in_word.bitmap_byte;
    q_job.fore    = fore_r;
    q_job.back    = back_r;
    if (in_word.action == lwmbe_pkg::ACT_WINDOW) begin
      q_job.kind = lwmbe_pkg::JOB_WINDOW;
    end else begin
      q_job.kind = lwmbe_pkg::JOB_PIXELS;
    end
    if (remain >= lwmbe_pkg::EXT_W'(lwmbe_pkg::PIX_PER_BYTE)) begin
      q_job.count = lwmbe_pkg::STEP_W'(lwmbe_pkg::PIX_PER_BYTE);
    end else begin
      q_job.count = remain[lwmbe_pkg::STEP_W-1:0];
    end
  end

  assign q_push = accept && ((in_word.action == lwmbe_pkg::ACT_WINDOW) || pix_ok);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    fore_nxt   = fore_r;
    back_nxt   = back_r;
    if (accept) begin
      if (in_word.action == lwmbe_pkg::ACT_WINDOW) begin
        width_nxt  = w_clamp;
        height_nxt = h_clamp;
        col_nxt    = '0;
        row_nxt    = '0;
        fore_nxt   = in_word.fore_color;
        back_nxt   = in_word.back_color;
      end else if (pix_ok) begin
        if (col_step >= width_r) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      fore_r   <= '0;
      back_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      fore_r   <= fore_nxt;
      back_r   <= back_nxt;
    end
  end

endmodule

>>> rtl/core/lwmbe_queue.sv
// Short job queue between the front end and the write sequencer.
module lwmbe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lwmbe_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lwmbe_pkg::job_t head_job
);

  lwmbe_pkg::job_t              mem_r [lwmbe_pkg::QDEPTH];
  logic [lwmbe_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lwmbe_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lwmbe_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full     = (cnt_r == lwmbe_pkg::QCNT_W'(lwmbe_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/lwmbe_back.sv
// Write sequencer: expands queued jobs into bus words, one per cycle unless the output stalls.
module lwmbe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  lwmbe_pkg::job_t      q_job,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output lwmbe_pkg::out_word_t out_word
);

  logic [lwmbe_pkg::STEP_W-1:0] step_r, step_nxt;
  lwmbe_pkg::out_word_t         out_r;
  logic                         out_valid_r, out_valid_nxt;
  lwmbe_pkg::out_word_t         word;
  logic                         advance;
  logic [2:0]                   bit_idx;

  assign advance = !q_empty && (!out_valid_r || out_pop);
  assign bit_idx = 3'd7 - step_r[2:0];

  always_comb begin
    word = '0;
    if (q_job.kind == lwmbe_pkg::JOB_WINDOW) begin
      word.is_data = 1'b1;
      case (step_r)
        lwmbe_pkg::WS_COL_CMD: begin
          word.is_data   = 1'b0;
          word.bus_value = 16'(lwmbe_pkg::CMD_COLUMN);
        end
        lwmbe_pkg::WS_XS_HI: word.bus_value = 16'(q_job.x_start[11:8]);
        lwmbe_pkg::WS_XS_LO: word.bus_value = 16'(q_job.x_start[7:0]);
        lwmbe_pkg::WS_XE_HI: word.bus_value = 16'(q_job.x_end[15:8]);
        lwmbe_pkg::WS_XE_LO: word.bus_value = 16'(q_job.x_end[7:0]);
        lwmbe_pkg::WS_ROW_CMD: begin
          word.is_data   = 1'b0;
          word.bus_value = 16'(lwmbe_pkg::CMD_ROW);
        end
        lwmbe_pkg::WS_YS_HI: word.bus_value = 16'(q_job.y_start[11:8]);
        lwmbe_pkg::WS_YS_LO: word.bus_value = 16'(q_job.y_start[7:0]);
        lwmbe_pkg::WS_YE_HI: word.bus_value = 16'(q_job.y_end[15:8]);
        lwmbe_pkg::WS_YE_LO: word.bus_value = 16'(q_job.y_end[7:0]);
        lwmbe_pkg::WS_FMT_CMD: begin
          word.is_data   = 1'b0;
          word.bus_value = 16'(lwmbe_pkg::CMD_PIXFMT);
        end
        lwmbe_pkg::WS_FMT_DAT: word.bus_value = 16'(lwmbe_pkg::PIXFMT_565);
        lwmbe_pkg::WS_MEM_CMD: begin
          word.is_data   = 1'b0;
          word.bus_value = 16'(lwmbe_pkg::CMD_MEMWRITE);
          word.last      = 1'b1;
        end
        default: word.bus_value = '0;
      endcase
    end else begin
      word.is_data   = 1'b1;
      word.bus_value = q_job.bits[bit_idx] ? q_job.fore : q_job.back;
      word.last      = (step_r == q_job.count - 1'b1);
    end
  end

  assign q_pop = advance && word.last;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      step_nxt      = word.last ? '0 : step_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

endmodule
